@@ rtl/tpsa_pkg.sv @@
// Shared constants, types and search functions for the two-pool slot allocator.
package tpsa_pkg;

  localparam int SMALL_SLOTS = 8;
  localparam int LARGE_SLOTS = 8;
  localparam int SMALL_SHIFT = 5;  // 32-byte small slots
  localparam int LARGE_SHIFT = 6;  // 64-byte large slots

  localparam int SLOT_W = 4;
  localparam int OFFSET_W = 10;
  localparam int MAP_W = 8;
  localparam int IN_TDATA_W = 8;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 32;

  localparam logic [OFFSET_W-1:0] LARGE_BASE = OFFSET_W'(SMALL_SLOTS << SMALL_SHIFT);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    SIZE_SMALL = 1'b0,
    SIZE_LARGE = 1'b1
  } size_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   idx;
  } hit_t;

  typedef struct packed {
    logic                success;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_offset;
  } result_t;

  // Lowest clear bit of the small map.
  function automatic hit_t first_free_small(input logic [SMALL_SLOTS-1:0] map);
    hit_t h;
    h = '0;
    for (int i = SMALL_SLOTS - 1; i >= 0; i--) begin
      if (!map[i]) begin
        h.found = 1'b1;
        h.idx   = SLOT_W'(i);
      end
    end
    return h;
  endfunction

  // Lowest clear bit of the large map.
  function automatic hit_t first_free_large(input logic [LARGE_SLOTS-1:0] map);
    hit_t h;
    h = '0;
    for (int i = LARGE_SLOTS - 1; i >= 0; i--) begin
      if (!map[i]) begin
        h.found = 1'b1;
        h.idx   = SLOT_W'(i);
      end
    end
    return h;
  endfunction

  // Lowest pair of adjacent clear bits in the small map.
  function automatic hit_t first_pair_small(input logic [SMALL_SLOTS-1:0] map);
    hit_t h;
    h = '0;
    for (int i = SMALL_SLOTS - 2; i >= 0; i--) begin
      if (!map[i] && !map[i+1]) begin
        h.found = 1'b1;
        h.idx   = SLOT_W'(i);
      end
    end
    return h;
  endfunction

endpackage

@@ rtl/two_pool_bitmap_slot_allocator_unit.sv @@
// Two-pool bitmap slot allocator: input register, first-fit stage, result register.
// The input word waits in the input register and passes through the first-fit stage into
// the result register when that register is empty or being taken. Throughput: one word per
// cycle while results are taken; the bitmaps update in the same edge that loads the result.
// The input register stalls only when the result register is full and not taken.
// Reset (rst_n low, synchronous) empties both registers and marks every slot free.
module two_pool_bitmap_slot_allocator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tpsa_pkg::IN_TDATA_W-1:0]      in_tdata,   // [3:0] free_slot, [7:4] zero
  input  logic [tpsa_pkg::IN_TUSER_W-1:0]      in_tuser,   // [0] op, [1] item_size
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] slot, [13:4] byte_offset, [21:14] small_occupancy, [29:22] large_occupancy
  output logic [tpsa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tuser   // [0] success
);

  logic                             in_valid_r;
  logic                             op_r;
  logic                             size_r;
  logic [tpsa_pkg::SLOT_W-1:0]      slot_r;
  logic [tpsa_pkg::SMALL_SLOTS-1:0] small_map_r;
  logic [tpsa_pkg::LARGE_SLOTS-1:0] large_map_r;
  logic                             out_valid_r;
  tpsa_pkg::result_t                res_r;

  tpsa_pkg::result_t                res_nxt;
  logic [tpsa_pkg::SMALL_SLOTS-1:0] small_map_nxt;
  logic [tpsa_pkg::LARGE_SLOTS-1:0] large_map_nxt;
  logic                             advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  tpsa_pick u_pick (
    .op             (op_r),
    .item_size      (size_r),
    .free_slot      (slot_r),
    .small_map      (small_map_r),
    .large_map      (large_map_r),
    .result         (res_nxt),
    .small_map_next (small_map_nxt),
    .large_map_next (large_map_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      small_map_r <= '0;
      large_map_r <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        small_map_r <= small_map_nxt;
        large_map_r <= large_map_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tuser[0];
      size_r <= in_tuser[1];
      slot_r <= in_tdata[tpsa_pkg::SLOT_W-1:0];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // occupancy fields show the maps as of the word in the result register
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.success;
  assign out_tdata  = {2'b00,
                       tpsa_pkg::MAP_W'(large_map_r),
                       tpsa_pkg::MAP_W'(small_map_r),
                       res_r.byte_offset,
                       res_r.slot};

endmodule

@@ rtl/tpsa_pick.sv @@
// Combinational first-fit search, free decode and next bitmap values.
module tpsa_pick (
  input  logic                             op,
  input  logic                             item_size,
  input  logic [tpsa_pkg::SLOT_W-1:0]      free_slot,
  input  logic [tpsa_pkg::SMALL_SLOTS-1:0] small_map,
  input  logic [tpsa_pkg::LARGE_SLOTS-1:0] large_map,
  output tpsa_pkg::result_t                result,
  output logic [tpsa_pkg::SMALL_SLOTS-1:0] small_map_next,
  output logic [tpsa_pkg::LARGE_SLOTS-1:0] large_map_next
);

  tpsa_pkg::hit_t s_hit;
  tpsa_pkg::hit_t l_hit;
  tpsa_pkg::hit_t p_hit;
  logic [tpsa_pkg::SLOT_W:0] large_rel;
  logic [tpsa_pkg::SLOT_W:0] pair_hi;

  assign s_hit     = tpsa_pkg::first_free_small(small_map);
  assign l_hit     = tpsa_pkg::first_free_large(large_map);
  assign p_hit     = tpsa_pkg::first_pair_small(small_map);
  assign large_rel = {1'b0, free_slot} - (tpsa_pkg::SLOT_W + 1)'(tpsa_pkg::SMALL_SLOTS);
  assign pair_hi   = {1'b0, free_slot} + (tpsa_pkg::SLOT_W + 1)'(1);

  function automatic logic [tpsa_pkg::OFFSET_W-1:0] small_off(
    input logic [tpsa_pkg::SLOT_W-1:0] idx);
    return tpsa_pkg::OFFSET_W'(idx) << tpsa_pkg::SMALL_SHIFT;
  endfunction

  function automatic logic [tpsa_pkg::OFFSET_W-1:0] large_off(
    input logic [tpsa_pkg::SLOT_W-1:0] idx);
    return tpsa_pkg::LARGE_BASE + (tpsa_pkg::OFFSET_W'(idx) << tpsa_pkg::LARGE_SHIFT);
  endfunction

  always_comb begin
    result         = '0;
    small_map_next = small_map;
    large_map_next = large_map;
    if (op == tpsa_pkg::OP_ALLOC) begin
      if (item_size == tpsa_pkg::SIZE_SMALL) begin
        priority if (s_hit.found) begin
          small_map_next[s_hit.idx[$clog2(tpsa_pkg::SMALL_SLOTS)-1:0]] = 1'b1;
          result.success     = 1'b1;
          result.slot        = s_hit.idx;
          result.byte_offset = small_off(s_hit.idx);
        end else if (l_hit.found) begin
          // small pool full: spill into the large pool
          large_map_next[l_hit.idx[$clog2(tpsa_pkg::LARGE_SLOTS)-1:0]] = 1'b1;
          result.success     = 1'b1;
          result.slot        = tpsa_pkg::SLOT_W'(tpsa_pkg::SMALL_SLOTS) + l_hit.idx;
          result.byte_offset = large_off(l_hit.idx);
        end else begin
          // no room anywhere: fail, maps unchanged
          result = '0;
        end
      end else begin
        priority if (l_hit.found) begin
          large_map_next[l_hit.idx[$clog2(tpsa_pkg::LARGE_SLOTS)-1:0]] = 1'b1;
          result.success     = 1'b1;
          result.slot        = tpsa_pkg::SLOT_W'(tpsa_pkg::SMALL_SLOTS) + l_hit.idx;
          result.byte_offset = large_off(l_hit.idx);
        end else if (p_hit.found) begin
          // large pool full: take two adjacent small slots
          small_map_next[p_hit.idx[$clog2(tpsa_pkg::SMALL_SLOTS)-1:0]]     = 1'b1;
          small_map_next[p_hit.idx[$clog2(tpsa_pkg::SMALL_SLOTS)-1:0] + 1'b1] = 1'b1;
          result.success     = 1'b1;
          result.slot        = p_hit.idx;
          result.byte_offset = small_off(p_hit.idx);
        end else begin
          result = '0;
        end
      end
    end else begin
      result.success = 1'b1;
      result.slot    = free_slot;
      priority if (32'(free_slot) < tpsa_pkg::SMALL_SLOTS) begin
        small_map_next[free_slot[$clog2(tpsa_pkg::SMALL_SLOTS)-1:0]] = 1'b0;
        // upper half of a pair beyond the pool is ignored
        if (item_size == tpsa_pkg::SIZE_LARGE && 32'(pair_hi) < tpsa_pkg::SMALL_SLOTS) begin
          small_map_next[pair_hi[$clog2(tpsa_pkg::SMALL_SLOTS)-1:0]] = 1'b0;
        end
        result.byte_offset = small_off(free_slot);
      end else if (32'(large_rel) < tpsa_pkg::LARGE_SLOTS) begin
        large_map_next[large_rel[$clog2(tpsa_pkg::LARGE_SLOTS)-1:0]] = 1'b0;
        result.byte_offset = large_off(large_rel[tpsa_pkg::SLOT_W-1:0]);
      end else begin
        // beyond both pools: nothing cleared, offset zero
        result.byte_offset = '0;
      end
    end
  end

endmodule

@@ rtl/tpsa_checker.sv @@
// Port-level checker for the slot allocator, bound to the top level.
module tpsa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tpsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input is open whenever the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // a failed allocation reports slot and offset zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[13:0] == 14'd0)
    else $error("failed allocation with nonzero slot or offset");

  // small slot offsets are slot times 32, large ones 256 plus index times 64
  a_slot_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[13:4] == (out_tdata[3] ? 10'd256 + {1'b0, out_tdata[2:0], 6'b0}
                                       : {2'b00, out_tdata[2:0], 5'b0}))
    else $error("slot offset mismatch");

endmodule

bind two_pool_bitmap_slot_allocator_unit tpsa_checker u_tpsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
